@@ hw/rtl/stma_pkg.sv @@
// ----------------------------------------------------------------------------
// stma_pkg
// Shared types, codes and defaults for the sparse triplet matrix adder.
// ----------------------------------------------------------------------------
package stma_pkg;

	localparam int MAX_TERMS_DEF = 32;
	localparam int MAX_DIM_DEF   = 256;

	localparam int IDX_W  = 8;
	localparam int VAL_W  = 32;
	localparam int SUM_W  = 33;
	localparam int DIM_W  = 9;
	localparam int CNT_W  = 7;

	localparam logic [1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [1:0] FUNC_START  = 2'd2;

	localparam logic [1:0] ST_ENTRY    = 2'd0;
	localparam logic [1:0] ST_MISMATCH = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam logic [1:0] REG_A_ROWS = 2'd0;
	localparam logic [1:0] REG_A_COLS = 2'd1;
	localparam logic [1:0] REG_B_ROWS = 2'd2;
	localparam logic [1:0] REG_B_COLS = 2'd3;

	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} trip_t;

	typedef struct packed {
		logic load;
		logic clear;
	} list_ctl_t;

endpackage

@@ hw/rtl/stma_list.sv @@
// ----------------------------------------------------------------------------
// stma_list
// One triplet list: a synchronous memory with a fill count and a
// registered read port.
// ----------------------------------------------------------------------------
module stma_list #(
	parameter int MAX_TERMS = stma_pkg::MAX_TERMS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  stma_pkg::list_ctl_t                   ctl,
	input  stma_pkg::trip_t                       wdata,
	input  logic [((MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1)-1:0] raddr,
	output stma_pkg::trip_t                       rdata,
	output logic [$clog2(MAX_TERMS+1)-1:0]        count,
	output logic                                  full
);

	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS+1);

	stma_pkg::trip_t mem [MAX_TERMS];
	stma_pkg::trip_t rdata_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(MAX_TERMS));
	assign count = count_q;
	assign rdata = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.load && !full) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && !full) begin
			mem[count_q[AW-1:0]] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

@@ hw/rtl/sparse_triplet_matrix_add_top.sv @@
// ----------------------------------------------------------------------------
// sparse_triplet_matrix_add_top
// Adds two sparse matrices held as row-major triplet lists and streams the
// merged entries, with a count and a last mark on the final result.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  in        in_valid / in_stall     func, row, col, value
//  out       out_valid / out_stall   out_row, out_col, out_value, status,
//                                    entry_count, last
//  config    cfg_we                  cfg_index, cfg_data
//
// A load request is accepted whenever the merge is idle. A start request
// holds off input until its merged entries, its error or its empty result
// have left the merge; the merge takes one step per cycle while the output
// register is free, set by the single read port of each list memory.
// Results wait in an output register, so a stalled output only pauses the
// merge. Reset empties both lists at once.
// ----------------------------------------------------------------------------
module sparse_triplet_matrix_add_top #(
	parameter int MAX_TERMS = stma_pkg::MAX_TERMS_DEF,
	parameter int MAX_DIM   = stma_pkg::MAX_DIM_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [stma_pkg::DIM_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         func,
	input  logic [stma_pkg::IDX_W-1:0]         row,
	input  logic [stma_pkg::IDX_W-1:0]         col,
	input  logic signed [stma_pkg::VAL_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [stma_pkg::IDX_W-1:0]         out_row,
	output logic [stma_pkg::IDX_W-1:0]         out_col,
	output logic signed [stma_pkg::SUM_W-1:0]  out_value,
	output logic [1:0]                         status,
	output logic [stma_pkg::CNT_W-1:0]         entry_count,
	output logic                               last
);

	localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW    = $clog2(MAX_TERMS+1);
	localparam int DW    = stma_pkg::DIM_W;
	localparam int CLAMP = (MAX_DIM > 511) ? 511 : MAX_DIM;
	localparam int SUM_W = stma_pkg::SUM_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_ERR  = 2'd2;

	logic [1:0]    state_q;
	logic [DW-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic          ovf_q;
	logic [1:0]    err_q;

	logic [CW-1:0] m_q, n_q, m_d, n_d;
	logic          started_q;
	logic [stma_pkg::IDX_W-1:0] last_row_q, last_col_q;

	logic                              cand_v_q;
	logic [stma_pkg::IDX_W-1:0]        cand_row_q, cand_col_q;
	logic signed [stma_pkg::SUM_W-1:0] cand_val_q;
	logic [stma_pkg::CNT_W-1:0]        k_q;

	logic                              out_v_q;
	logic [stma_pkg::IDX_W-1:0]        out_row_q, out_col_q;
	logic signed [stma_pkg::SUM_W-1:0] out_val_q;
	logic [1:0]                        out_st_q;
	logic [stma_pkg::CNT_W-1:0]        out_cnt_q;
	logic                              out_last_q;

	stma_pkg::list_ctl_t ctl_a, ctl_b;
	stma_pkg::trip_t     wdata, head_a, head_b;
	logic [CW-1:0]       cnt_a, cnt_b;
	logic                full_a, full_b;

	logic in_acc, out_free, finish;
	logic load_a, load_b, start;
	logic [DW-1:0] rows_eff, cols_eff;
	logic va, vb, take_a, take_b, step;
	logic [stma_pkg::IDX_W-1:0]        new_row, new_col;
	logic signed [stma_pkg::SUM_W-1:0] sum_a, sum_b, new_val;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign load_a   = in_acc && (func == stma_pkg::FUNC_LOAD_A);
	assign load_b   = in_acc && (func == stma_pkg::FUNC_LOAD_B);
	assign start    = in_acc && (func == stma_pkg::FUNC_START);
	assign out_free = !out_v_q || !out_stall;

	assign wdata.row   = row;
	assign wdata.col   = col;
	assign wdata.value = value;

	assign finish = out_free && (((state_q == S_RUN) && !va && !vb) || (state_q == S_ERR));

	assign ctl_a.load  = load_a;
	assign ctl_a.clear = finish;
	assign ctl_b.load  = load_b;
	assign ctl_b.clear = finish;

	assign rows_eff = (a_rows_q > DW'(CLAMP)) ? DW'(CLAMP) : a_rows_q;
	assign cols_eff = (a_cols_q > DW'(CLAMP)) ? DW'(CLAMP) : a_cols_q;

	always_comb begin
		va = (m_q < cnt_a) && ({1'b0, head_a.row} < rows_eff) && ({1'b0, head_a.col} < cols_eff)
			&& (!started_q || (head_a.row > last_row_q)
			|| ((head_a.row == last_row_q) && (head_a.col > last_col_q)));
		vb = (n_q < cnt_b) && ({1'b0, head_b.row} < rows_eff) && ({1'b0, head_b.col} < cols_eff)
			&& (!started_q || (head_b.row > last_row_q)
			|| ((head_b.row == last_row_q) && (head_b.col > last_col_q)));
		take_a = va && (!vb || (head_a.row < head_b.row)
			|| ((head_a.row == head_b.row) && (head_a.col <= head_b.col)));
		take_b = vb && (!va || (head_b.row < head_a.row)
			|| ((head_b.row == head_a.row) && (head_b.col <= head_a.col)));
		step  = (state_q == S_RUN) && out_free && (va || vb);
		sum_a = SUM_W'(head_a.value);
		sum_b = SUM_W'(head_b.value);
		if (take_a) begin
			new_row = head_a.row;
			new_col = head_a.col;
		end else begin
			new_row = head_b.row;
			new_col = head_b.col;
		end
		if (take_a && take_b) begin
			new_val = sum_a + sum_b;
		end else if (take_a) begin
			new_val = sum_a;
		end else begin
			new_val = sum_b;
		end
		m_d = m_q;
		n_d = n_q;
		if (start) begin
			m_d = '0;
			n_d = '0;
		end else if (step) begin
			if (take_a) begin
				m_d = m_q + CW'(1);
			end
			if (take_b) begin
				n_d = n_q + CW'(1);
			end
		end
	end

	stma_list #(.MAX_TERMS(MAX_TERMS)) u_list_a (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl_a),
		.wdata (wdata),
		.raddr (m_d[AW-1:0]),
		.rdata (head_a),
		.count (cnt_a),
		.full  (full_a)
	);

	stma_list #(.MAX_TERMS(MAX_TERMS)) u_list_b (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl_b),
		.wdata (wdata),
		.raddr (n_d[AW-1:0]),
		.rdata (head_b),
		.count (cnt_b),
		.full  (full_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= '0;
			a_cols_q <= '0;
			b_rows_q <= '0;
			b_cols_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				stma_pkg::REG_A_ROWS: a_rows_q <= cfg_data;
				stma_pkg::REG_A_COLS: a_cols_q <= cfg_data;
				stma_pkg::REG_B_ROWS: b_rows_q <= cfg_data;
				stma_pkg::REG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ovf_q     <= 1'b0;
			err_q     <= stma_pkg::ST_ENTRY;
			m_q       <= '0;
			n_q       <= '0;
			started_q <= 1'b0;
			cand_v_q  <= 1'b0;
			k_q       <= '0;
			out_v_q   <= 1'b0;
		end else begin
			m_q <= m_d;
			n_q <= n_d;
			if ((load_a && full_a) || (load_b && full_b)) begin
				ovf_q <= 1'b1;
			end
			if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						started_q <= 1'b0;
						cand_v_q  <= 1'b0;
						k_q       <= '0;
						if ((a_rows_q != b_rows_q) || (a_cols_q != b_cols_q)) begin
							err_q   <= stma_pkg::ST_MISMATCH;
							state_q <= S_ERR;
						end else if (ovf_q) begin
							err_q   <= stma_pkg::ST_OVERFLOW;
							state_q <= S_ERR;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (step) begin
						started_q <= 1'b1;
						cand_v_q  <= 1'b1;
						k_q       <= k_q + stma_pkg::CNT_W'(1);
						if (cand_v_q) begin
							out_v_q <= 1'b1;
						end
					end else if (finish) begin
						out_v_q <= 1'b1;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_ERR: begin
					if (finish) begin
						out_v_q <= 1'b1;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			last_row_q <= new_row;
			last_col_q <= new_col;
			cand_row_q <= new_row;
			cand_col_q <= new_col;
			cand_val_q <= new_val;
			out_row_q  <= cand_row_q;
			out_col_q  <= cand_col_q;
			out_val_q  <= cand_val_q;
			out_st_q   <= stma_pkg::ST_ENTRY;
			out_cnt_q  <= '0;
			out_last_q <= 1'b0;
		end else if (finish) begin
			out_last_q <= 1'b1;
			if ((state_q == S_RUN) && cand_v_q) begin
				out_row_q <= cand_row_q;
				out_col_q <= cand_col_q;
				out_val_q <= cand_val_q;
				out_st_q  <= stma_pkg::ST_ENTRY;
				out_cnt_q <= k_q;
			end else begin
				out_row_q <= '0;
				out_col_q <= '0;
				out_val_q <= '0;
				out_cnt_q <= '0;
				out_st_q  <= (state_q == S_ERR) ? err_q : stma_pkg::ST_EMPTY;
			end
		end
	end

	assign out_valid   = out_v_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign out_value   = out_val_q;
	assign status      = out_st_q;
	assign entry_count = out_cnt_q;
	assign last        = out_last_q;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sparse triplet matrix adder. A short directed
// sequence covers value extremes, zero sums, copies from either list, size
// mismatch, out-of-order, duplicate and out-of-range entries and the unused
// code. Randomized load sets follow, mostly sorted lists with shared
// positions, plus noise and list overflow. Every merged entry is compared
// with a behavioral prediction; two random phases idle both handshakes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAX_TERMS     = stma_pkg::MAX_TERMS_DEF;
	localparam int MAX_DIM       = stma_pkg::MAX_DIM_DEF;
	localparam int IDX_W         = stma_pkg::IDX_W;
	localparam int VAL_W         = stma_pkg::VAL_W;
	localparam int SUM_W         = stma_pkg::SUM_W;
	localparam int DIM_W         = stma_pkg::DIM_W;
	localparam int CNT_W         = stma_pkg::CNT_W;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_ITEMS   = 140;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [SUM_W-1:0] value;
		logic [1:0]              status;
		logic [CNT_W-1:0]        count;
		logic                    last;
	} sum_entry_t;

	typedef struct {
		bit                      set_dims;
		bit                      typed;
		logic [1:0]              func;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
		logic [DIM_W-1:0]        ar, ac, br, bc;
		logic [1:0]              typed_status;
	} plan_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [1:0]                cfg_index = stma_pkg::REG_A_ROWS;
	logic [DIM_W-1:0]          cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                func = stma_pkg::FUNC_LOAD_A;
	logic [IDX_W-1:0]          row = '0;
	logic [IDX_W-1:0]          col = '0;
	logic signed [VAL_W-1:0]   value = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [IDX_W-1:0]          out_row;
	logic [IDX_W-1:0]          out_col;
	logic signed [SUM_W-1:0]   out_value;
	logic [1:0]                status;
	logic [CNT_W-1:0]          entry_count;
	logic                      last;

	sparse_triplet_matrix_add_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.row         (row),
		.col         (col),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_row     (out_row),
		.out_col     (out_col),
		.out_value   (out_value),
		.status      (status),
		.entry_count (entry_count),
		.last        (last)
	);

	always #5 clk = ~clk;

	// Mirror of the block state.
	stma_pkg::trip_t  list_a [MAX_TERMS];
	stma_pkg::trip_t  list_b [MAX_TERMS];
	int               cnt_a = 0;
	int               cnt_b = 0;
	bit               overflowed = 1'b0;
	logic [DIM_W-1:0] dim_ar = '0, dim_ac = '0, dim_br = '0, dim_bc = '0;

	sum_entry_t pending_sums [$];
	plan_row_t  plan [$];
	int         errors = 0;
	int         items_sent = 0;
	int         cycle_count = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		errors++;
	endtask

	function automatic void push_status(input logic [1:0] st);
		sum_entry_t e;
		e = '{default: '0};
		e.status = st;
		e.last = 1'b1;
		pending_sums.push_back(e);
	endfunction

	function automatic void merge_lists();
		sum_entry_t got [$];
		sum_entry_t e;
		int         rows, cols, m, n, pos, ka, kb;
		bit         va, vb;
		if (dim_ar != dim_br || dim_ac != dim_bc) begin
			push_status(stma_pkg::ST_MISMATCH);
			return;
		end
		if (overflowed) begin
			push_status(stma_pkg::ST_OVERFLOW);
			return;
		end
		rows = (dim_ar > MAX_DIM) ? MAX_DIM : int'(dim_ar);
		cols = (dim_ac > MAX_DIM) ? MAX_DIM : int'(dim_ac);
		m = 0;
		n = 0;
		pos = 0;
		forever begin
			va = 1'b0;
			vb = 1'b0;
			ka = 0;
			kb = 0;
			if (m < cnt_a && list_a[m].row < rows && list_a[m].col < cols) begin
				ka = int'(list_a[m].row) * cols + int'(list_a[m].col);
				va = (ka >= pos);
			end
			if (n < cnt_b && list_b[n].row < rows && list_b[n].col < cols) begin
				kb = int'(list_b[n].row) * cols + int'(list_b[n].col);
				vb = (kb >= pos);
			end
			if (!va && !vb)
				break;
			e = '{default: '0};
			e.status = stma_pkg::ST_ENTRY;
			if (va && vb && ka == kb) begin
				e.row = list_a[m].row;
				e.col = list_a[m].col;
				e.value = {list_a[m].value[VAL_W-1], list_a[m].value}
					+ {list_b[n].value[VAL_W-1], list_b[n].value};
				pos = ka + 1;
				m++;
				n++;
			end else if (va && (!vb || ka < kb)) begin
				e.row = list_a[m].row;
				e.col = list_a[m].col;
				e.value = {list_a[m].value[VAL_W-1], list_a[m].value};
				pos = ka + 1;
				m++;
			end else begin
				e.row = list_b[n].row;
				e.col = list_b[n].col;
				e.value = {list_b[n].value[VAL_W-1], list_b[n].value};
				pos = kb + 1;
				n++;
			end
			got.push_back(e);
		end
		if (got.size() == 0) begin
			push_status(stma_pkg::ST_EMPTY);
			return;
		end
		got[got.size()-1].count = CNT_W'(got.size());
		got[got.size()-1].last = 1'b1;
		foreach (got[i])
			pending_sums.push_back(got[i]);
	endfunction

	function automatic void apply_request(input logic [1:0] f, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [VAL_W-1:0] v,
			input bit typed, input logic [1:0] typed_st);
		case (f)
			stma_pkg::FUNC_LOAD_A: begin
				if (cnt_a >= MAX_TERMS) begin
					overflowed = 1'b1;
				end else begin
					list_a[cnt_a] = '{row: r, col: c, value: v};
					cnt_a++;
				end
			end
			stma_pkg::FUNC_LOAD_B: begin
				if (cnt_b >= MAX_TERMS) begin
					overflowed = 1'b1;
				end else begin
					list_b[cnt_b] = '{row: r, col: c, value: v};
					cnt_b++;
				end
			end
			stma_pkg::FUNC_START: begin
				if (typed)
					push_status(typed_st);
				else
					merge_lists();
				cnt_a = 0;
				cnt_b = 0;
				overflowed = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic send_req(input logic [1:0] f, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [VAL_W-1:0] v,
			input bit typed, input logic [1:0] typed_st);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		row <= r;
		col <= c;
		value <= v;
		do
			@(posedge clk);
		while (in_stall);
		apply_request(f, r, c, v, typed, typed_st);
		if (f != FUNC_UNUSED)
			items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			stma_pkg::REG_A_ROWS: dim_ar = d;
			stma_pkg::REG_A_COLS: dim_ac = d;
			stma_pkg::REG_B_ROWS: dim_br = d;
			default:              dim_bc = d;
		endcase
		@(posedge clk);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
			input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc);
		write_reg(stma_pkg::REG_A_ROWS, ar);
		write_reg(stma_pkg::REG_A_COLS, ac);
		write_reg(stma_pkg::REG_B_ROWS, br);
		write_reg(stma_pkg::REG_B_COLS, bc);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [DIM_W-1:0] pick_dim();
		int p;
		p = $urandom_range(99);
		if (p < 5)
			return '0;
		if (p < 12)
			return DIM_W'(MAX_DIM);
		if (p < 20)
			return DIM_W'($urandom_range(1, MAX_DIM));
		return DIM_W'($urandom_range(1, 12));
	endfunction

	task automatic choose_dims();
		logic [DIM_W-1:0] ar, ac, br, bc;
		ar = pick_dim();
		ac = pick_dim();
		br = ar;
		bc = ac;
		if ($urandom_range(9) == 0) begin
			if ($urandom_range(1))
				br = pick_dim();
			else
				bc = pick_dim();
		end
		set_dims(ar, ac, br, bc);
	endtask

	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(9))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] rand_index();
		if ($urandom_range(1))
			return IDX_W'($urandom_range(0, 255));
		return IDX_W'($urandom_range(0, 15));
	endfunction

	function automatic void sort_unique(ref int q [$]);
		int uq [$];
		q.sort();
		foreach (q[i])
			if (i == 0 || q[i] != q[i-1])
				uq.push_back(q[i]);
		q = uq;
	endfunction

	// One load set into both lists followed by a start request.
	task automatic random_burst();
		int              rows, cols, space, mode, na, nb, cap;
		int              keys_a [$], keys_b [$];
		stma_pkg::trip_t ents_a [$], ents_b [$];
		stma_pkg::trip_t t;
		if ($urandom_range(99) < 25) begin
			wait_drained();
			choose_dims();
		end
		rows = (dim_ar > MAX_DIM) ? MAX_DIM : int'(dim_ar);
		cols = (dim_ac > MAX_DIM) ? MAX_DIM : int'(dim_ac);
		space = rows * cols;
		mode = $urandom_range(99);
		if (mode < 6) begin
			na = $urandom_range(0, 5);
			nb = $urandom_range(0, 5);
			if ($urandom_range(1))
				na = MAX_TERMS + $urandom_range(1, 3);
			else
				nb = MAX_TERMS + $urandom_range(1, 3);
			repeat (na) ents_a.push_back('{rand_index(), rand_index(), rand_value()});
			repeat (nb) ents_b.push_back('{rand_index(), rand_index(), rand_value()});
		end else if (mode < 16 || space == 0) begin
			mode = 10;
			repeat ($urandom_range(0, 6))
				ents_a.push_back('{rand_index(), rand_index(), rand_value()});
			repeat ($urandom_range(0, 6))
				ents_b.push_back('{rand_index(), rand_index(), rand_value()});
		end else begin
			cap = ($urandom_range(9) == 0) ? MAX_TERMS : 10;
			na = $urandom_range(0, cap);
			nb = $urandom_range(0, cap);
			repeat (na) keys_a.push_back($urandom_range(0, space - 1));
			sort_unique(keys_a);
			repeat (nb) begin
				if (keys_a.size() != 0 && $urandom_range(1))
					keys_b.push_back(keys_a[$urandom_range(0, keys_a.size() - 1)]);
				else
					keys_b.push_back($urandom_range(0, space - 1));
			end
			sort_unique(keys_b);
			foreach (keys_a[i])
				ents_a.push_back('{IDX_W'(keys_a[i] / cols), IDX_W'(keys_a[i] % cols),
					rand_value()});
			foreach (keys_b[i])
				ents_b.push_back('{IDX_W'(keys_b[i] / cols), IDX_W'(keys_b[i] % cols),
					rand_value()});
		end
		while (ents_a.size() != 0 || ents_b.size() != 0) begin
			if (mode == 10 && $urandom_range(7) == 0)
				send_req(FUNC_UNUSED, rand_index(), rand_index(), rand_value(), 1'b0,
					stma_pkg::ST_ENTRY);
			if (ents_b.size() == 0 || (ents_a.size() != 0 && $urandom_range(1))) begin
				t = ents_a.pop_front();
				send_req(stma_pkg::FUNC_LOAD_A, t.row, t.col, t.value, 1'b0,
					stma_pkg::ST_ENTRY);
			end else begin
				t = ents_b.pop_front();
				send_req(stma_pkg::FUNC_LOAD_B, t.row, t.col, t.value, 1'b0,
					stma_pkg::ST_ENTRY);
			end
		end
		if ($urandom_range(9) == 0)
			wait_drained();
		send_req(stma_pkg::FUNC_START, rand_index(), rand_index(), rand_value(), 1'b0,
			stma_pkg::ST_ENTRY);
	endtask

	function automatic plan_row_t req(input logic [1:0] f, input int r, input int c,
			input logic signed [VAL_W-1:0] v);
		plan_row_t p;
		p = '{default: '0};
		p.func = f;
		p.row = IDX_W'(r);
		p.col = IDX_W'(c);
		p.value = v;
		return p;
	endfunction

	function automatic plan_row_t start_typed(input logic [1:0] st);
		plan_row_t p;
		p = req(stma_pkg::FUNC_START, 0, 0, '0);
		p.typed = 1'b1;
		p.typed_status = st;
		return p;
	endfunction

	function automatic plan_row_t dims(input int ar, input int ac, input int br, input int bc);
		plan_row_t p;
		p = '{default: '0};
		p.set_dims = 1'b1;
		p.ar = DIM_W'(ar);
		p.ac = DIM_W'(ac);
		p.br = DIM_W'(br);
		p.bc = DIM_W'(bc);
		return p;
	endfunction

	always @(posedge clk) begin : result_check
		sum_entry_t e;
		out_stall <= ($urandom_range(99) < recv_idle_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sums.size() == 0) begin
				report_mismatch($sformatf("unexpected result row %0d col %0d status %0d",
					out_row, out_col, status));
			end else begin
				e = pending_sums.pop_front();
				if (out_row !== e.row)
					report_mismatch($sformatf("out_row %0d, expected %0d", out_row, e.row));
				if (out_col !== e.col)
					report_mismatch($sformatf("out_col %0d, expected %0d", out_col, e.col));
				if (out_value !== e.value)
					report_mismatch($sformatf("out_value %0d, expected %0d",
						out_value, e.value));
				if (status !== e.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, e.status));
				if (entry_count !== e.count)
					report_mismatch($sformatf("entry_count %0d, expected %0d",
						entry_count, e.count));
				if (last !== e.last)
					report_mismatch($sformatf("last %0d, expected %0d", last, e.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int target;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan.push_back(start_typed(stma_pkg::ST_EMPTY));
		plan.push_back(dims(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM));
		plan.push_back(req(stma_pkg::FUNC_LOAD_A, 0, 0, 32'sh7fffffff));
		plan.push_back(req(stma_pkg::FUNC_LOAD_B, 0, 0, 32'sh7fffffff));
		plan.push_back(req(stma_pkg::FUNC_LOAD_A, 5, 7, -32'sd1));
		plan.push_back(req(stma_pkg::FUNC_LOAD_B, 5, 7, 32'sd1));
		plan.push_back(req(stma_pkg::FUNC_LOAD_A, 255, 255, 32'sh80000000));
		plan.push_back(req(stma_pkg::FUNC_LOAD_B, 255, 255, 32'sh80000000));
		plan.push_back(req(stma_pkg::FUNC_START, 0, 0, '0));
		plan.push_back(dims(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM - 1));
		plan.push_back(req(stma_pkg::FUNC_LOAD_A, 1, 1, 32'sd3));
		plan.push_back(start_typed(stma_pkg::ST_MISMATCH));
		plan.push_back(dims(4, 5, 4, 5));
		// List A goes out of order and list B repeats a position.
		plan.push_back(req(stma_pkg::FUNC_LOAD_A, 1, 2, 32'sd10));
		plan.push_back(req(stma_pkg::FUNC_LOAD_A, 0, 1, 32'sd5));
		plan.push_back(req(stma_pkg::FUNC_LOAD_B, 0, 0, 32'sd7));
		plan.push_back(req(FUNC_UNUSED, 255, 255, -32'sd1));
		plan.push_back(req(stma_pkg::FUNC_LOAD_B, 3, 4, -32'sd3));
		plan.push_back(req(stma_pkg::FUNC_LOAD_B, 3, 4, 32'sd2));
		plan.push_back(req(stma_pkg::FUNC_START, 255, 255, -32'sd1));
		plan.push_back(req(stma_pkg::FUNC_LOAD_B, 200, 1, 32'sd5));
		plan.push_back(start_typed(stma_pkg::ST_EMPTY));
		plan.push_back(dims(0, 0, 0, 0));
		plan.push_back(req(stma_pkg::FUNC_LOAD_A, 0, 0, 32'sd1));
		plan.push_back(start_typed(stma_pkg::ST_EMPTY));

		foreach (plan[i]) begin
			if (plan[i].set_dims) begin
				wait_drained();
				set_dims(plan[i].ar, plan[i].ac, plan[i].br, plan[i].bc);
			end else begin
				send_req(plan[i].func, plan[i].row, plan[i].col, plan[i].value,
					plan[i].typed, plan[i].typed_status);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 60 : 0;
			recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 22 : 0;
			wait_drained();
			choose_dims();
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_burst();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
